// ===== hdl/ttx_pkg.sv =====
// ----------------------------------------------------------------------------
// ttx_pkg
// Shared constants and types of the tour tail crossover block.
// ----------------------------------------------------------------------------
package ttx_pkg;

   localparam int MAX_GENES_DEF = 64;
   localparam int GENE_BITS_DEF = 6;

   localparam int TOUR_LEN_W = 7;
   localparam int TAIL_LEN_W = 6;
   localparam int MIN_TOUR_LEN = 4;
   localparam logic [TOUR_LEN_W-1:0] TOUR_LEN_RESET = 7'd32;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index decoded from paddr[2]
   localparam logic REG_TOUR_LENGTH = 1'b0;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MASK  = 5'b00010,
      ST_CROSS = 5'b00100,
      ST_TAIL  = 5'b01000,
      ST_EMIT  = 5'b10000
   } ttx_state_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic do_mask;
      logic do_cross;
      logic do_tail;
      logic do_emit;
      logic last_pos;
   } ttx_cmd_type;

   typedef struct packed {
      logic pipe_busy;
   } ttx_sts_type;

endpackage

// ===== hdl/tour_tail_crossover_core.sv =====
// ----------------------------------------------------------------------------
// tour_tail_crossover_core
// Tail crossover of two parent tours into two child tours.
//
// Input: a beat is taken when start is high and busy is low. Each beat
// writes one gene of parent A and one of parent B at the next position
// while the stores are not full; beats without req_last return nothing.
// A beat with req_last builds both children and then emits one gene pair
// per cycle on the rsp_ ports, qualified by rsp_strobe, positions 0 up to
// len-1, rsp_end_of_tour on the final pair. The receiver cannot stall.
// With len the clamped tour length, tail the clamped tail length and
// head = len - tail, the build walks the parent stores three times over a
// single shared read address: positions 0 to head-1 for the presence
// masks, 0 to head-1 again for the cross fill, head to len-1 for the own
// tail; emit then walks positions 0 to len-1. busy stays high from the
// closing beat until the final pair is emitted.
// Reset: tour length 32, load position zero, no results pending.
// ----------------------------------------------------------------------------
module tour_tail_crossover_core
   import ttx_pkg::*;
#(
   parameter int MAX_GENES = MAX_GENES_DEF,
   parameter int GENE_BITS = GENE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [GENE_BITS-1:0]         req_gene_a,
   input  logic [GENE_BITS-1:0]         req_gene_b,
   input  logic [TAIL_LEN_W-1:0]        req_tail_length,
   input  logic                         req_last,
   output logic                         rsp_strobe,
   output logic [GENE_BITS-1:0]         rsp_child_a_gene,
   output logic [GENE_BITS-1:0]         rsp_child_b_gene,
   output logic [$clog2(MAX_GENES)-1:0] rsp_position,
   output logic                         rsp_end_of_tour,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [CSR_DATA_W-1:0]        csr_pwdata,
   output logic [CSR_DATA_W-1:0]        csr_prdata,
   output logic                         csr_pready
);

   localparam int AW = $clog2(MAX_GENES);
   localparam int CW = $clog2(MAX_GENES + 1);

   logic [TOUR_LEN_W-1:0] tour_length;
   ttx_cmd_type           cmd;
   ttx_sts_type           sts;
   logic [AW-1:0]         load_addr;
   logic [AW-1:0]         rd_addr;
   logic [CW-1:0]         len;
   logic [CW-1:0]         head;

   ttx_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .tour_length (tour_length)
   );

   ttx_ctrl #(.MAX_GENES(MAX_GENES)) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_last        (req_last),
      .req_tail_length (req_tail_length),
      .tour_length     (tour_length),
      .sts             (sts),
      .cmd             (cmd),
      .load_addr       (load_addr),
      .rd_addr         (rd_addr),
      .len             (len),
      .head            (head)
   );

   ttx_datapath #(.MAX_GENES(MAX_GENES), .GENE_BITS(GENE_BITS)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .load_addr        (load_addr),
      .rd_addr          (rd_addr),
      .len              (len),
      .head             (head),
      .req_gene_a       (req_gene_a),
      .req_gene_b       (req_gene_b),
      .rsp_strobe       (rsp_strobe),
      .rsp_child_a_gene (rsp_child_a_gene),
      .rsp_child_b_gene (rsp_child_b_gene),
      .rsp_position     (rsp_position),
      .rsp_end_of_tour  (rsp_end_of_tour)
   );

endmodule

// ===== hdl/ttx_ram.sv =====
// ----------------------------------------------------------------------------
// ttx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ttx_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ttx_csr.sv =====
// ----------------------------------------------------------------------------
// ttx_csr
// Register file on the APB-style port: tour length register.
// ----------------------------------------------------------------------------
module ttx_csr
   import ttx_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [TOUR_LEN_W-1:0] tour_length
);

   logic [TOUR_LEN_W-1:0] tour_length_ff;
   logic [TOUR_LEN_W-1:0] tour_length_in;
   logic                  reg_index;
   logic                  wr_beat;

   assign reg_index = csr_paddr[2];
   assign wr_beat   = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      tour_length_in = tour_length_ff;
      if (wr_beat && reg_index == REG_TOUR_LENGTH) begin
         tour_length_in = csr_pwdata[TOUR_LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tour_length_ff <= TOUR_LEN_RESET;
      end else begin
         tour_length_ff <= tour_length_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_index == REG_TOUR_LENGTH) begin
         csr_prdata = CSR_DATA_W'(tour_length_ff);
      end
   end

   assign csr_pready  = 1'b1;
   assign tour_length = tour_length_ff;

endmodule

// ===== hdl/ttx_ctrl.sv =====
// ----------------------------------------------------------------------------
// ttx_ctrl
// Sequencer: loads parent genes, then walks mask, cross, tail and emit passes.
// ----------------------------------------------------------------------------
module ttx_ctrl
   import ttx_pkg::*;
#(
   parameter int MAX_GENES = MAX_GENES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_last,
   input  logic [TAIL_LEN_W-1:0]          req_tail_length,
   input  logic [TOUR_LEN_W-1:0]          tour_length,
   input  ttx_sts_type                    sts,
   output ttx_cmd_type                    cmd,
   output logic [$clog2(MAX_GENES)-1:0]   load_addr,
   output logic [$clog2(MAX_GENES)-1:0]   rd_addr,
   output logic [$clog2(MAX_GENES+1)-1:0] len,
   output logic [$clog2(MAX_GENES+1)-1:0] head
);

   localparam int AW = $clog2(MAX_GENES);
   localparam int CW = $clog2(MAX_GENES + 1);
   localparam logic [CW-1:0] ONE = CW'(1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_GENES);
   localparam logic [TOUR_LEN_W-1:0] LEN_MIN = TOUR_LEN_W'(MIN_TOUR_LEN);
   localparam logic [TOUR_LEN_W-1:0] LEN_MAX = TOUR_LEN_W'(MAX_GENES);

   ttx_state_type         state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [CW-1:0]         len_ff, len_in;
   logic [CW-1:0]         head_ff, head_in;
   logic                  accept;
   logic [TOUR_LEN_W-1:0] len_clamp;
   logic [TOUR_LEN_W-1:0] half;
   logic [TOUR_LEN_W-1:0] tail_ext;
   logic [TOUR_LEN_W-1:0] tail_clamp;

   assign busy   = (state_ff != ST_IDLE) | sts.pipe_busy;
   assign accept = start & ~busy;

   always_comb begin
      len_clamp = tour_length;
      if (tour_length < LEN_MIN) begin
         len_clamp = LEN_MIN;
      end else if (tour_length > LEN_MAX) begin
         len_clamp = LEN_MAX;
      end
      half       = len_clamp >> 1;
      tail_ext   = TOUR_LEN_W'(req_tail_length);
      tail_clamp = tail_ext;
      if (tail_ext == '0) begin
         tail_clamp = TOUR_LEN_W'(1);
      end else if (tail_ext > half) begin
         tail_clamp = half;
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      len_in   = len_ff;
      head_in  = head_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = (count_ff < MAX_CNT);
               if (req_last) begin
                  count_in = '0;
                  idx_in   = '0;
                  len_in   = CW'(len_clamp);
                  head_in  = CW'(len_clamp - tail_clamp);
                  state_in = ST_MASK;
               end else if (count_ff < MAX_CNT) begin
                  count_in = count_ff + ONE;
               end
            end
         end
         ST_MASK: begin
            cmd.do_mask = 1'b1;
            cmd.clear   = (idx_ff == '0);
            if (idx_ff == head_ff - ONE) begin
               idx_in   = '0;
               state_in = ST_CROSS;
            end else begin
               idx_in = idx_ff + ONE;
            end
         end
         ST_CROSS: begin
            cmd.do_cross = 1'b1;
            if (idx_ff == head_ff - ONE) begin
               idx_in   = head_ff;
               state_in = ST_TAIL;
            end else begin
               idx_in = idx_ff + ONE;
            end
         end
         ST_TAIL: begin
            cmd.do_tail = 1'b1;
            if (idx_ff == len_ff - ONE) begin
               idx_in   = '0;
               state_in = ST_EMIT;
            end else begin
               idx_in = idx_ff + ONE;
            end
         end
         ST_EMIT: begin
            cmd.do_emit  = 1'b1;
            cmd.last_pos = (idx_ff == len_ff - ONE);
            if (idx_ff == len_ff - ONE) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + ONE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      head_ff <= head_in;
   end

   assign load_addr = count_ff[AW-1:0];
   assign rd_addr   = idx_ff[AW-1:0];
   assign len       = len_ff;
   assign head      = head_ff;

endmodule

// ===== hdl/ttx_datapath.sv =====
// ----------------------------------------------------------------------------
// ttx_datapath
// Parent stores, child tail stores, presence masks and the result register.
// ----------------------------------------------------------------------------
module ttx_datapath
   import ttx_pkg::*;
#(
   parameter int MAX_GENES = MAX_GENES_DEF,
   parameter int GENE_BITS = GENE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ttx_cmd_type                    cmd,
   output ttx_sts_type                    sts,
   input  logic [$clog2(MAX_GENES)-1:0]   load_addr,
   input  logic [$clog2(MAX_GENES)-1:0]   rd_addr,
   input  logic [$clog2(MAX_GENES+1)-1:0] len,
   input  logic [$clog2(MAX_GENES+1)-1:0] head,
   input  logic [GENE_BITS-1:0]           req_gene_a,
   input  logic [GENE_BITS-1:0]           req_gene_b,
   output logic                           rsp_strobe,
   output logic [GENE_BITS-1:0]           rsp_child_a_gene,
   output logic [GENE_BITS-1:0]           rsp_child_b_gene,
   output logic [$clog2(MAX_GENES)-1:0]   rsp_position,
   output logic                           rsp_end_of_tour
);

   localparam int AW = $clog2(MAX_GENES);
   localparam int CW = $clog2(MAX_GENES + 1);
   localparam int NG = 1 << GENE_BITS;
   localparam logic [CW-1:0] ONE = CW'(1);

   logic [GENE_BITS-1:0] ga, gb, ta, tb;
   logic [GENE_BITS-1:0] cand_a, cand_b;
   logic                 fill_a, fill_b;

   logic                 s1_mask_ff, s1_cross_ff, s1_tail_ff, s1_emit_ff, s1_last_ff;
   logic [AW-1:0]        s1_pos_ff;
   logic [CW-1:0]        pos_ext;

   logic [NG-1:0]        mask_a_ff, mask_a_in, mask_b_ff, mask_b_in;
   logic [NG-1:0]        placed_a_ff, placed_a_in, placed_b_ff, placed_b_in;
   logic [CW-1:0]        ind_a_ff, ind_a_in, ind_b_ff, ind_b_in;

   logic                 rsp_strobe_ff, rsp_end_ff;
   logic [GENE_BITS-1:0] rsp_a_ff, rsp_a_in, rsp_b_ff, rsp_b_in;
   logic [AW-1:0]        rsp_pos_ff;

   ttx_ram #(.WIDTH(GENE_BITS), .DEPTH(MAX_GENES)) u_parent_a (
      .clock   (clock),
      .wr_en   (cmd.load),
      .wr_addr (load_addr),
      .wr_data (req_gene_a),
      .rd_addr (rd_addr),
      .rd_data (ga)
   );

   ttx_ram #(.WIDTH(GENE_BITS), .DEPTH(MAX_GENES)) u_parent_b (
      .clock   (clock),
      .wr_en   (cmd.load),
      .wr_addr (load_addr),
      .wr_data (req_gene_b),
      .rd_addr (rd_addr),
      .rd_data (gb)
   );

   ttx_ram #(.WIDTH(GENE_BITS), .DEPTH(MAX_GENES)) u_tail_a (
      .clock   (clock),
      .wr_en   (fill_a),
      .wr_addr (ind_a_ff[AW-1:0]),
      .wr_data (cand_a),
      .rd_addr (rd_addr),
      .rd_data (ta)
   );

   ttx_ram #(.WIDTH(GENE_BITS), .DEPTH(MAX_GENES)) u_tail_b (
      .clock   (clock),
      .wr_en   (fill_b),
      .wr_addr (ind_b_ff[AW-1:0]),
      .wr_data (cand_b),
      .rd_addr (rd_addr),
      .rd_data (tb)
   );

   // candidate gene and fill decision for each child
   always_comb begin
      cand_a = s1_cross_ff ? gb : ga;
      cand_b = s1_cross_ff ? ga : gb;
      fill_a = ((s1_cross_ff & ~mask_a_ff[gb]) | (s1_tail_ff & ~placed_a_ff[ga]))
               & (ind_a_ff < len);
      fill_b = ((s1_cross_ff & ~mask_b_ff[ga]) | (s1_tail_ff & ~placed_b_ff[gb]))
               & (ind_b_ff < len);
   end

   always_comb begin
      mask_a_in   = mask_a_ff;
      mask_b_in   = mask_b_ff;
      placed_a_in = placed_a_ff;
      placed_b_in = placed_b_ff;
      ind_a_in    = ind_a_ff;
      ind_b_in    = ind_b_ff;
      if (cmd.clear) begin
         mask_a_in   = '0;
         mask_b_in   = '0;
         placed_a_in = '0;
         placed_b_in = '0;
         ind_a_in    = head;
         ind_b_in    = head;
      end else begin
         if (s1_mask_ff) begin
            mask_a_in[ga] = 1'b1;
            mask_b_in[gb] = 1'b1;
         end
         if (fill_a) begin
            placed_a_in[cand_a] = 1'b1;
            ind_a_in            = ind_a_ff + ONE;
         end
         if (fill_b) begin
            placed_b_in[cand_b] = 1'b1;
            ind_b_in            = ind_b_ff + ONE;
         end
      end
   end

   // head genes and unfilled tail slots keep the own parent gene
   always_comb begin
      pos_ext  = CW'(s1_pos_ff);
      rsp_a_in = ((pos_ext < head) || (pos_ext >= ind_a_ff)) ? ga : ta;
      rsp_b_in = ((pos_ext < head) || (pos_ext >= ind_b_ff)) ? gb : tb;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_mask_ff    <= 1'b0;
         s1_cross_ff   <= 1'b0;
         s1_tail_ff    <= 1'b0;
         s1_emit_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_mask_ff    <= cmd.do_mask;
         s1_cross_ff   <= cmd.do_cross;
         s1_tail_ff    <= cmd.do_tail;
         s1_emit_ff    <= cmd.do_emit;
         rsp_strobe_ff <= s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff  <= cmd.last_pos;
      s1_pos_ff   <= rd_addr;
      mask_a_ff   <= mask_a_in;
      mask_b_ff   <= mask_b_in;
      placed_a_ff <= placed_a_in;
      placed_b_ff <= placed_b_in;
      ind_a_ff    <= ind_a_in;
      ind_b_ff    <= ind_b_in;
      rsp_a_ff    <= rsp_a_in;
      rsp_b_ff    <= rsp_b_in;
      rsp_pos_ff  <= s1_pos_ff;
      rsp_end_ff  <= s1_last_ff;
   end

   assign sts.pipe_busy    = s1_mask_ff | s1_cross_ff | s1_tail_ff | s1_emit_ff;
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_child_a_gene = rsp_a_ff;
   assign rsp_child_b_gene = rsp_b_ff;
   assign rsp_position     = rsp_pos_ff;
   assign rsp_end_of_tour  = rsp_strobe_ff & rsp_end_ff;

endmodule

// ===== hdl/ttx_checker.sv =====
// ----------------------------------------------------------------------------
// ttx_checker
// Port-level checks of the result sequence and of load beats, bound to the top level.
// ----------------------------------------------------------------------------
module ttx_checker
   import ttx_pkg::*;
#(
   parameter int MAX_GENES = MAX_GENES_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         req_last,
   input logic                         rsp_strobe,
   input logic [$clog2(MAX_GENES)-1:0] rsp_position,
   input logic                         rsp_end_of_tour
);

   localparam int AW = $clog2(MAX_GENES);

   a_busy_mid_tour: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_end_of_tour |-> busy)
      else $error("busy low while a tour is still being emitted");

   a_beats_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_end_of_tour |=> rsp_strobe)
      else $error("gap in result beats before end of tour");

   a_position_step: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_end_of_tour |=>
         rsp_position == AW'($past(rsp_position) + 1'b1))
      else $error("result position did not advance by one");

   a_end_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_end_of_tour |=> !rsp_strobe)
      else $error("result beat after end of tour");

   a_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_last |=> !busy)
      else $error("load beat left the block busy");

endmodule

bind tour_tail_crossover_core ttx_checker #(.MAX_GENES(MAX_GENES)) u_ttx_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_last        (req_last),
   .rsp_strobe      (rsp_strobe),
   .rsp_position    (rsp_position),
   .rsp_end_of_tour (rsp_end_of_tour)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for tour_tail_crossover_core. Parent gene pairs are
// driven through the start/busy handshake and the tour length through the
// APB register port. A scoreboard keeps its own copy of both parent stores,
// builds both children on every closing beat and checks every child gene
// pair that leaves the block. The run covers clamped tour and tail lengths,
// short tours that reuse old store entries, store overflow, parents that are
// not permutations, and several sender idle rates.
// ----------------------------------------------------------------------------
module testbench
   import ttx_pkg::*;
();

   localparam int GENES = MAX_GENES_DEF;
   localparam int GBITS = GENE_BITS_DEF;
   localparam int POS_W = $clog2(GENES);
   localparam int STALL_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES = 200;

   typedef logic [GBITS-1:0] gene_type;
   typedef gene_type tour_type [GENES];

   typedef struct {
      gene_type          a;
      gene_type          b;
      logic [POS_W-1:0]  pos;
      logic              eot;
   } child_pair_type;

   class crossover_scoreboard;
      tour_type          store_a;
      tour_type          store_b;
      int                loaded;
      int                tour_len_reg;
      child_pair_type    pairs_due[$];
      int                mismatches;
      int                pairs_checked;
      int                tours_built;

      function new();
         loaded = 0;
         tour_len_reg = int'(TOUR_LEN_RESET);
         mismatches = 0;
         pairs_checked = 0;
         tours_built = 0;
      endfunction

      function void set_tour_length(input logic [TOUR_LEN_W-1:0] value);
         tour_len_reg = int'(value);
      endfunction

      function int tour_span();
         if (tour_len_reg < MIN_TOUR_LEN) return MIN_TOUR_LEN;
         if (tour_len_reg > GENES) return GENES;
         return tour_len_reg;
      endfunction

      function void log_mismatch(input string msg);
         mismatches++;
         if (mismatches <= 10) $display("mismatch: %s", msg);
      endfunction

      function void cross_tail(input tour_type own, input tour_type other, input int len,
                               input int tail, output tour_type kid);
         int head;
         int fill;
         logic [GENES-1:0] head_set;
         logic [GENES-1:0] placed;
         head = len - tail;
         fill = head;
         head_set = '0;
         placed = '0;
         kid = own;
         for (int i = 0; i < head; i++) head_set[own[i]] = 1'b1;
         for (int i = 0; i < head; i++) begin
            if (!head_set[other[i]] && fill < len) begin
               kid[fill] = other[i];
               fill++;
               placed[other[i]] = 1'b1;
            end
         end
         for (int i = head; i < len; i++) begin
            if (!placed[own[i]] && fill < len) begin
               kid[fill] = own[i];
               fill++;
               placed[own[i]] = 1'b1;
            end
         end
      endfunction

      function void note_parent_genes(input gene_type ga, input gene_type gb,
                                      input logic [TAIL_LEN_W-1:0] tail_in,
                                      input logic last);
         int len;
         int tail;
         tour_type kid_a;
         tour_type kid_b;
         child_pair_type pair;
         if (loaded < GENES) begin
            store_a[loaded] = ga;
            store_b[loaded] = gb;
            loaded++;
         end
         if (!last) return;
         len = tour_span();
         tail = int'(tail_in);
         if (tail < 1) tail = 1;
         if (tail > len / 2) tail = len / 2;
         cross_tail(store_a, store_b, len, tail, kid_a);
         cross_tail(store_b, store_a, len, tail, kid_b);
         loaded = 0;
         tours_built++;
         for (int p = 0; p < len; p++) begin
            pair.a = kid_a[p];
            pair.b = kid_b[p];
            pair.pos = POS_W'(p);
            pair.eot = (p == len - 1);
            pairs_due.push_back(pair);
         end
      endfunction

      function void check_child_pair(input gene_type a, input gene_type b,
                                     input logic [POS_W-1:0] pos, input logic eot);
         child_pair_type want;
         if (pairs_due.size() == 0) begin
            log_mismatch($sformatf("unexpected pair pos %0d a %0d b %0d end %0b",
                                   pos, a, b, eot));
            return;
         end
         want = pairs_due.pop_front();
         pairs_checked++;
         if (pos !== want.pos)
            log_mismatch($sformatf("position exp %0d got %0d", want.pos, pos));
         if (a !== want.a)
            log_mismatch($sformatf("pos %0d child A exp %0d got %0d", want.pos, want.a, a));
         if (b !== want.b)
            log_mismatch($sformatf("pos %0d child B exp %0d got %0d", want.pos, want.b, b));
         if (eot !== want.eot)
            log_mismatch($sformatf("pos %0d end flag exp %0b got %0b",
                                   want.pos, want.eot, eot));
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   gene_type                req_gene_a;
   gene_type                req_gene_b;
   logic [TAIL_LEN_W-1:0]   req_tail_length;
   logic                    req_last;
   logic                    rsp_strobe;
   gene_type                rsp_child_a_gene;
   gene_type                rsp_child_b_gene;
   logic [POS_W-1:0]        rsp_position;
   logic                    rsp_end_of_tour;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CSR_ADDR_W-1:0]   csr_paddr;
   logic [CSR_DATA_W-1:0]   csr_pwdata;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   crossover_scoreboard     sb;
   int                      idle_pct;
   int                      beats_sent;
   int                      fill_pos;
   int                      written_depth;
   int                      quiet_cycles;

   tour_tail_crossover_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_gene_a       (req_gene_a),
      .req_gene_b       (req_gene_b),
      .req_tail_length  (req_tail_length),
      .req_last         (req_last),
      .rsp_strobe       (rsp_strobe),
      .rsp_child_a_gene (rsp_child_a_gene),
      .rsp_child_b_gene (rsp_child_b_gene),
      .rsp_position     (rsp_position),
      .rsp_end_of_tour  (rsp_end_of_tour),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_child_pair(rsp_child_a_gene, rsp_child_b_gene, rsp_position,
                             rsp_end_of_tour);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", quiet_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic program_tour_length(input logic [TOUR_LEN_W-1:0] value);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {REG_TOUR_LENGTH, 2'b00};
      csr_pwdata = CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_tour_length(value);
      @(negedge clock);
      csr_pwrite = 1'b0;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[TOUR_LEN_W-1:0] !== value)
         sb.log_mismatch($sformatf("tour length readback exp %0d got %0d", value,
                                   csr_prdata[TOUR_LEN_W-1:0]));
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic send_beat(input gene_type ga, input gene_type gb,
                            input logic [TAIL_LEN_W-1:0] tail, input logic last);
      while ($urandom_range(0, 99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_gene_a = ga;
      req_gene_b = gb;
      req_tail_length = tail;
      req_last = last;
      do @(posedge clock); while (busy);
      sb.note_parent_genes(ga, gb, tail, last);
      beats_sent++;
      if (fill_pos < GENES) fill_pos++;
      if (fill_pos > written_depth) written_depth = fill_pos;
      if (last) fill_pos = 0;
      @(negedge clock);
   endtask

   task automatic drain_and_settle();
      start = 1'b0;
      while (sb.pairs_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic void shuffle_genes(ref gene_type deck[$]);
      int j;
      gene_type t;
      for (int i = deck.size() - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = deck[i];
         deck[i] = deck[j];
         deck[j] = t;
      end
   endfunction

   task automatic run_tour(input int n, input bit permuted, input logic [TAIL_LEN_W-1:0] tail);
      gene_type cities[$];
      gene_type ga[$];
      gene_type gb[$];
      int k;
      k = (n < GENES) ? n : GENES;
      for (int i = 0; i < GENES; i++) cities.push_back(gene_type'(i));
      if ($urandom_range(0, 3) == 0) shuffle_genes(cities);
      cities = cities[0:k-1];
      ga = cities;
      gb = cities;
      shuffle_genes(ga);
      shuffle_genes(gb);
      while (ga.size() < n) begin
         ga.push_back(gene_type'($urandom));
         gb.push_back(gene_type'($urandom));
      end
      if (!permuted) begin
         foreach (ga[i]) begin
            ga[i] = gene_type'($urandom);
            if ($urandom_range(0, 1)) gb[i] = ga[i];
            else gb[i] = gene_type'($urandom);
         end
      end
      for (int i = 0; i < n; i++)
         send_beat(ga[i], gb[i],
                   (i == n - 1) ? tail : TAIL_LEN_W'($urandom), i == n - 1);
   endtask

   task automatic run_phase(input logic [TOUR_LEN_W-1:0] tour_len, input int pct,
                            input int quota);
      int len;
      int first_beat;
      int pick;
      int n;
      bit permuted;
      logic [TAIL_LEN_W-1:0] tail;
      program_tour_length(tour_len);
      idle_pct = pct;
      len = sb.tour_span();
      first_beat = beats_sent;
      while (beats_sent - first_beat < quota) begin
         pick = $urandom_range(0, 99);
         if (pick < 4)
            n = GENES + $urandom_range(1, 6);
         else if (pick < 18 && written_depth >= len)
            n = $urandom_range(1, len - 1);
         else if (pick < 26)
            n = len + $urandom_range(1, 4);
         else
            n = len;
         permuted = ($urandom_range(0, 99) >= 15);
         if ($urandom_range(0, 3) == 0)
            tail = TAIL_LEN_W'($urandom);
         else
            tail = TAIL_LEN_W'($urandom_range(1, len / 2));
         run_tour(n, permuted, tail);
         if ($urandom_range(0, 5) == 0) drain_and_settle();
      end
      drain_and_settle();
   endtask

   initial begin
      sb = new();
      idle_pct = 0;
      beats_sent = 0;
      fill_pos = 0;
      written_depth = 0;
      quiet_cycles = 0;
      reset = 1'b1;
      start = 1'b0;
      req_gene_a = '0;
      req_gene_b = '0;
      req_tail_length = '0;
      req_last = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: shortest tour, clamped tails, extreme genes, broken parents
      program_tour_length(7'd4);
      send_beat(6'd0, 6'd3, 6'h3F, 1'b0);
      send_beat(6'd1, 6'd2, 6'h00, 1'b0);
      send_beat(6'd2, 6'd1, 6'h3F, 1'b0);
      send_beat(6'd3, 6'd0, 6'd0, 1'b1);
      send_beat(6'd63, 6'd60, 6'h00, 1'b0);
      send_beat(6'd62, 6'd61, 6'h3F, 1'b0);
      send_beat(6'd61, 6'd63, 6'h15, 1'b0);
      send_beat(6'd60, 6'd62, 6'd63, 1'b1);
      send_beat(6'd63, 6'd0, 6'h2A, 1'b0);
      send_beat(6'd63, 6'd63, 6'h00, 1'b0);
      send_beat(6'd0, 6'd0, 6'h3F, 1'b0);
      send_beat(6'd0, 6'd63, 6'd2, 1'b1);
      send_beat(6'd5, 6'd9, 6'd1, 1'b1);
      send_beat(6'd10, 6'd15, 6'h00, 1'b0);
      send_beat(6'd11, 6'd14, 6'h3F, 1'b0);
      send_beat(6'd12, 6'd13, 6'h00, 1'b0);
      send_beat(6'd13, 6'd12, 6'h3F, 1'b0);
      send_beat(6'd14, 6'd11, 6'h00, 1'b0);
      send_beat(6'd15, 6'd10, 6'd32, 1'b1);
      drain_and_settle();

      run_phase(7'd127, 0, 60);
      run_phase(7'd0, 77, 50);
      run_phase(7'd64, 12, 60);
      run_phase(7'd5, 0, 40);
      run_phase(7'd33, 77, 50);
      run_phase(7'd4, 12, 40);
      run_phase(TOUR_LEN_W'($urandom_range(6, 63)), 0, 50);
      run_phase(TOUR_LEN_W'($urandom_range(65, 126)), 77, 50);

      drain_and_settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("run: %0d parent beats, %0d tours built, %0d child gene pairs checked",
               beats_sent, sb.tours_built, sb.pairs_checked);
      $display("run: tour length 0 to 127, clamped tails, overflow, short and broken tours");
      if (sb.mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== tour_tail_crossover_core.f =====
hdl/ttx_pkg.sv
hdl/ttx_ram.sv
hdl/ttx_csr.sv
hdl/ttx_ctrl.sv
hdl/ttx_datapath.sv
hdl/tour_tail_crossover_core.sv
hdl/ttx_checker.sv
sim/testbench.sv
